### rtl/uvs_pkg.sv
package uvs_pkg;

   // field widths
   localparam int IDX_W    = 11;
   localparam int CNT_W    = 11;
   localparam int RAD_W    = 16;
   localparam int CSR_DW   = 16;
   localparam int POS_W    = 17;
   localparam int NRM_W    = 16;
   localparam int TEX_W    = 17;

   // segment counts are clamped to this
   localparam int MAX_SEGMENTS = 1024;

   // angle phase in turns, two top bits select the quadrant
   localparam int ANG_W  = 16;
   localparam int QUAD_W = ANG_W - 2;

   // long division: quotient bits, numerator and denominator widths
   localparam int DIV_STEPS = ANG_W + 1;
   localparam int NUM_W     = IDX_W + ANG_W;
   localparam int DEN_W     = CNT_W + 1;

   // Q30 series arithmetic
   localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam int          SER_STEPS   = 7;

   // series divisors, row 0 for sine, row 1 for cosine; 0 means no step
   localparam logic [7:0] SER_DIV [2][SER_STEPS] = '{
      '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6,  8'd0},
      '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2}
   };

   // floor(2^32 / d) for the divisors above
   localparam logic [31:0] SER_RCP [2][SER_STEPS] = '{
      '{32'((64'd1 << 32) / 156), 32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72),
        32'((64'd1 << 32) / 42),  32'((64'd1 << 32) / 20),  32'((64'd1 << 32) / 6),
        32'd0},
      '{32'((64'd1 << 32) / 182), 32'((64'd1 << 32) / 132), 32'((64'd1 << 32) / 90),
        32'((64'd1 << 32) / 56),  32'((64'd1 << 32) / 30),  32'((64'd1 << 32) / 12),
        32'((64'd1 << 32) / 2)}
   };

   // register map
   typedef enum logic [1:0] {
      CSR_RADIUS   = 2'd0,
      CSR_LONG_SEG = 2'd1,
      CSR_LAT_SEG  = 2'd2
   } csr_index_type;

   // round to nearest, halves away from zero
   function automatic logic signed [63:0] shift_round(input logic signed [63:0] v,
                                                      input int sh);
      logic [63:0] mag;
      mag = v[63] ? 64'(-v) : 64'(v);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -$signed(mag) : $signed(mag);
   endfunction

   // symmetric saturation
   function automatic logic signed [63:0] sat_sym(input logic signed [63:0] v,
                                                  input logic signed [63:0] lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

endpackage

### rtl/uvs_if.sv
interface uvs_req_if;
   logic        valid;
   logic        ready;
   logic [10:0] long_index;
   logic [10:0] lat_index;
   modport source (output valid, long_index, lat_index, input ready);
   modport sink   (input valid, long_index, lat_index, output ready);
endinterface

interface uvs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] pos_x;
   logic signed [16:0] pos_y;
   logic signed [16:0] pos_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [16:0]        tex_u;
   logic [16:0]        tex_v;
   logic               bad_index;
   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   tex_u, tex_v, bad_index, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   tex_u, tex_v, bad_index, output ready);
endinterface

interface uvs_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/uv_sphere_vertex_generator_core.sv
// Channel   Dir  Beat contents
// req_ch    in   long_index, lat_index
// rsp_ch    out  pos_x/y/z, norm_x/y/z, tex_u, tex_v, bad_index
// csr_ch    in   index, data (register write, always ready)
//
// 46 register stages; one beat enters per cycle when not stalled.
// Depth is set by the 17-stage long divider and the 7-step sine/cosine series
// (multiply, reciprocal multiply, correct: three stages per step).
// Each stage holds a valid bit and loads when empty or when the next one moves,
// so bubbles close up under a stall and nothing is dropped or repeated.
// Synchronous active-high reset clears the valid bits and loads the register defaults.
module uv_sphere_vertex_generator_core (
   input logic       clock,
   input logic       reset,
   uvs_req_if.sink   req_ch,
   uvs_rsp_if.source rsp_ch,
   uvs_csr_if.sink   csr_ch
);
   import uvs_pkg::*;

   localparam int ST_DIV0 = 1;
   localparam int ST_T1   = ST_DIV0 + DIV_STEPS + 1;
   localparam int ST_T2   = ST_T1 + 1;
   localparam int SER_N   = 3 * SER_STEPS;
   localparam int ST_F    = ST_T2 + SER_N + 1;
   localparam int ST_P1   = ST_F + 1;
   localparam int ST_P2   = ST_P1 + 1;
   localparam int ST_P3   = ST_P2 + 1;
   localparam int NS      = ST_P3 + 1;

   typedef struct packed {
      logic                    bad;
      logic [TEX_W-1:0]        tex_u;
      logic [TEX_W-1:0]        tex_v;
      logic [1:0][1:0]         quad;
      logic [1:0][30:0]        x;
      logic [1:0][31:0]        x2;
   } trig_side_type;

   // ---------------- configuration registers ----------------
   logic [RAD_W-1:0] radius_ff;
   logic [CNT_W-1:0] long_seg_ff, lat_seg_ff;
   logic [CNT_W-1:0] lc, tc;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RAD_W'(256);
         long_seg_ff <= CNT_W'(16);
         lat_seg_ff  <= CNT_W'(16);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_RADIUS:   radius_ff   <= csr_ch.data;
            CSR_LONG_SEG: long_seg_ff <= csr_ch.data[CNT_W-1:0];
            CSR_LAT_SEG:  lat_seg_ff  <= csr_ch.data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective counts: zero acts as one, clamp at max
   always_comb begin
      lc = (long_seg_ff == '0) ? CNT_W'(1) :
           (long_seg_ff > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : long_seg_ff;
      tc = (lat_seg_ff == '0) ? CNT_W'(1) :
           (lat_seg_ff > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : lat_seg_ff;
   end

   // ---------------- valid chain ----------------
   logic [NS:1]   v_ff;
   logic [NS+1:1] rdy;
   logic [NS:1]   v_prev;

   always_comb begin
      rdy[NS+1] = rsp_ch.ready;
      for (int k = NS; k >= 1; k--) rdy[k] = !v_ff[k] || rdy[k+1];
      v_prev[1] = req_ch.valid;
      for (int k = 2; k <= NS; k++) v_prev[k] = v_ff[k-1];
   end

   assign req_ch.ready = rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NS; k++) if (rdy[k]) v_ff[k] <= v_prev[k];
      end
   end

   // ---------------- long divider, one quotient bit per stage ----------------
   // lane 0: theta and tex_u, lane 1: delta (den 2T), lane 2: tex_v
   logic [NUM_W-1:0]     div_num_ff [DIV_STEPS+1][3];
   logic [CNT_W-1:0]     div_rem_ff [DIV_STEPS+1][3];
   logic [DIV_STEPS-1:0] div_q_ff   [DIV_STEPS+1][3];
   logic                 div_bad_ff [DIV_STEPS+1];
   logic [DEN_W-1:0]     den [3];

   assign den[0] = DEN_W'(lc);
   assign den[1] = {tc, 1'b0};
   assign den[2] = DEN_W'(tc);

   // entry stage: numerators with the rounding half added
   always_ff @(posedge clock) begin
      logic [NUM_W-1:0] n;
      if (rdy[ST_DIV0]) begin
         div_bad_ff[0] <= (req_ch.long_index > lc) || (req_ch.lat_index > tc);
         for (int l = 0; l < 3; l++) begin
            n = (l == 0) ? {req_ch.long_index, ANG_W'(0)} + NUM_W'(lc >> 1) :
                (l == 1) ? {req_ch.lat_index, ANG_W'(0)} + NUM_W'(tc) :
                           {req_ch.lat_index, ANG_W'(0)} + NUM_W'(tc >> 1);
            div_num_ff[0][l] <= n;
            div_rem_ff[0][l] <= CNT_W'(n[NUM_W-1:DIV_STEPS]);
            div_q_ff[0][l]   <= '0;
         end
      end
   end

   for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
      always_ff @(posedge clock) begin
         logic [DEN_W-1:0] t;
         if (rdy[ST_DIV0 + i]) begin
            div_bad_ff[i] <= div_bad_ff[i-1];
            for (int l = 0; l < 3; l++) begin
               t = {div_rem_ff[i-1][l], div_num_ff[i-1][l][DIV_STEPS-i]};
               div_num_ff[i][l] <= div_num_ff[i-1][l];
               if (t >= den[l]) begin
                  div_rem_ff[i][l] <= CNT_W'(t - den[l]);
                  div_q_ff[i][l]   <= {div_q_ff[i-1][l][DIV_STEPS-2:0], 1'b1};
               end else begin
                  div_rem_ff[i][l] <= CNT_W'(t);
                  div_q_ff[i][l]   <= {div_q_ff[i-1][l][DIV_STEPS-2:0], 1'b0};
               end
            end
         end
      end
   end

   // ---------------- angle to radians ----------------
   trig_side_type t1_ff;

   always_ff @(posedge clock) begin
      logic [44:0] xw;
      logic [15:0] p;
      if (rdy[ST_T1]) begin
         t1_ff.bad   <= div_bad_ff[DIV_STEPS];
         t1_ff.tex_u <= div_q_ff[DIV_STEPS][0];
         t1_ff.tex_v <= div_q_ff[DIV_STEPS][2];
         t1_ff.x2    <= '0;
         for (int a = 0; a < 2; a++) begin
            p = div_q_ff[DIV_STEPS][a][ANG_W-1:0];
            xw = 45'(p[QUAD_W-1:0]) * 45'(HALF_PI_Q30) + 45'(1 << (QUAD_W - 1));
            t1_ff.quad[a] <= p[ANG_W-1:QUAD_W];
            t1_ff.x[a]    <= xw[QUAD_W+30:QUAD_W];
         end
      end
   end

   // ---------------- series pipeline ----------------
   // lanes: 0 sin theta, 1 cos theta, 2 sin delta, 3 cos delta
   trig_side_type sr_side_ff [SER_N+1];
   logic [30:0]   sr_t_ff    [SER_N+1][4];
   logic [31:0]   sr_n_ff    [SER_N+1][4];
   logic [31:0]   sr_qe_ff   [SER_N+1][4];

   always_ff @(posedge clock) begin
      logic [61:0]   xx;
      trig_side_type side_in;
      if (rdy[ST_T2]) begin
         side_in = t1_ff;
         for (int a = 0; a < 2; a++) begin
            xx = 62'(t1_ff.x[a]) * 62'(t1_ff.x[a]);
            side_in.x2[a] = xx[61:30];
         end
         sr_side_ff[0] <= side_in;
         for (int l = 0; l < 4; l++) begin
            sr_t_ff[0][l]  <= Q30_ONE[30:0];
            sr_n_ff[0][l]  <= '0;
            sr_qe_ff[0][l] <= '0;
         end
      end
   end

   for (genvar s = 1; s <= SER_N; s++) begin : g_ser
      localparam int J   = (s - 1) / 3;
      localparam int SUB = (s - 1) % 3;
      always_ff @(posedge clock) begin
         logic [62:0] pn;
         logic [63:0] pq;
         logic [39:0] r;
         logic [31:0] q;
         logic [30:0] t_in;
         logic [31:0] n_in;
         logic [31:0] qe_in;
         if (rdy[ST_T2 + s]) begin
            sr_side_ff[s] <= sr_side_ff[s-1];
            for (int l = 0; l < 4; l++) begin
               t_in  = sr_t_ff[s-1][l];
               n_in  = sr_n_ff[s-1][l];
               qe_in = sr_qe_ff[s-1][l];
               case (SUB)
                  0: begin
                     // x2 * t >> 30
                     pn = 63'(sr_side_ff[s-1].x2[l >> 1]) * 63'(sr_t_ff[s-1][l]);
                     n_in = pn[61:30];
                  end
                  1: begin
                     // quotient estimate, at most one short
                     pq = 64'(sr_n_ff[s-1][l]) * 64'(SER_RCP[l % 2][J]);
                     qe_in = pq[63:32];
                  end
                  default: begin
                     if (SER_DIV[l % 2][J] != 8'd0) begin
                        r = 40'(sr_n_ff[s-1][l])
                            - 40'(sr_qe_ff[s-1][l]) * 40'(SER_DIV[l % 2][J]);
                        q = (r >= 40'(SER_DIV[l % 2][J])) ? sr_qe_ff[s-1][l] + 32'd1
                                                          : sr_qe_ff[s-1][l];
                        t_in = (q > Q30_ONE) ? 31'd0 : 31'(Q30_ONE - q);
                     end
                  end
               endcase
               sr_t_ff[s][l]  <= t_in;
               sr_n_ff[s][l]  <= n_in;
               sr_qe_ff[s][l] <= qe_in;
            end
         end
      end
   end

   // ---------------- sine finish and quadrant map ----------------
   logic signed [31:0] sin_ff [2], cos_ff [2];
   logic               f_bad_ff;
   logic [TEX_W-1:0]   f_u_ff, f_v_ff;

   always_ff @(posedge clock) begin
      logic [61:0]        ps;
      logic signed [31:0] sv, cv;
      if (rdy[ST_F]) begin
         f_bad_ff <= sr_side_ff[SER_N].bad;
         f_u_ff   <= sr_side_ff[SER_N].tex_u;
         f_v_ff   <= sr_side_ff[SER_N].tex_v;
         for (int a = 0; a < 2; a++) begin
            ps = 62'(sr_side_ff[SER_N].x[a]) * 62'(sr_t_ff[SER_N][2*a]);
            sv = (ps[61:30] > Q30_ONE) ? $signed(Q30_ONE) : $signed(ps[61:30]);
            cv = $signed(32'(sr_t_ff[SER_N][2*a+1]));
            case (sr_side_ff[SER_N].quad[a])
               2'd0: begin sin_ff[a] <= sv;  cos_ff[a] <= cv;  end
               2'd1: begin sin_ff[a] <= cv;  cos_ff[a] <= -sv; end
               2'd2: begin sin_ff[a] <= -sv; cos_ff[a] <= -cv; end
               default: begin sin_ff[a] <= -cv; cos_ff[a] <= sv; end
            endcase
         end
      end
   end

   // ---------------- direction ----------------
   logic signed [63:0] p1_x_ff, p1_z_ff;
   logic signed [31:0] p1_y_ff;
   logic               p1_bad_ff;
   logic [TEX_W-1:0]   p1_u_ff, p1_v_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_P1]) begin
         p1_x_ff   <= 64'(cos_ff[0]) * 64'(sin_ff[1]);
         p1_z_ff   <= 64'(sin_ff[0]) * 64'(sin_ff[1]);
         p1_y_ff   <= cos_ff[1];
         p1_bad_ff <= f_bad_ff;
         p1_u_ff   <= f_u_ff;
         p1_v_ff   <= f_v_ff;
      end
   end

   logic signed [31:0] dir_ff [3];
   logic               p2_bad_ff;
   logic [TEX_W-1:0]   p2_u_ff, p2_v_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_P2]) begin
         dir_ff[0] <= 32'(shift_round(p1_x_ff, 30));
         dir_ff[1] <= p1_y_ff;
         dir_ff[2] <= 32'(shift_round(p1_z_ff, 30));
         p2_bad_ff <= p1_bad_ff;
         p2_u_ff   <= p1_u_ff;
         p2_v_ff   <= p1_v_ff;
      end
   end

   // ---------------- scale by radius, normal ----------------
   logic signed [48:0]      pp_ff  [3];
   logic signed [NRM_W-1:0] nrm_ff [3];
   logic                    p3_bad_ff;
   logic [TEX_W-1:0]        p3_u_ff, p3_v_ff;

   always_ff @(posedge clock) begin
      if (rdy[ST_P3]) begin
         for (int k = 0; k < 3; k++) begin
            pp_ff[k]  <= 49'($signed({1'b0, radius_ff})) * 49'(dir_ff[k]);
            nrm_ff[k] <= NRM_W'(sat_sym(shift_round(64'(dir_ff[k]), 15), 64'sd32767));
         end
         p3_bad_ff <= p2_bad_ff;
         p3_u_ff   <= p2_u_ff;
         p3_v_ff   <= p2_v_ff;
      end
   end

   // ---------------- output register ----------------
   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [NRM_W-1:0] on_ff  [3];
   logic [TEX_W-1:0]        u_ff, v_ff2;
   logic                    bad_ff;

   always_ff @(posedge clock) begin
      if (rdy[NS]) begin
         for (int k = 0; k < 3; k++) begin
            pos_ff[k] <= p3_bad_ff ? '0 :
                         POS_W'(sat_sym(shift_round(64'(pp_ff[k]), 30), 64'sd65535));
            on_ff[k]  <= p3_bad_ff ? '0 : nrm_ff[k];
         end
         u_ff   <= p3_bad_ff ? '0 : p3_u_ff;
         v_ff2  <= p3_bad_ff ? '0 : p3_v_ff;
         bad_ff <= p3_bad_ff;
      end
   end

   assign rsp_ch.valid     = v_ff[NS];
   assign rsp_ch.pos_x     = pos_ff[0];
   assign rsp_ch.pos_y     = pos_ff[1];
   assign rsp_ch.pos_z     = pos_ff[2];
   assign rsp_ch.norm_x    = on_ff[0];
   assign rsp_ch.norm_y    = on_ff[1];
   assign rsp_ch.norm_z    = on_ff[2];
   assign rsp_ch.tex_u     = u_ff;
   assign rsp_ch.tex_v     = v_ff2;
   assign rsp_ch.bad_index = bad_ff;

   // ---------------- assertions ----------------
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.bad_index |->
         rsp_ch.pos_x == '0 && rsp_ch.norm_y == '0 && rsp_ch.tex_u == '0)
      else $error("bad index beat carries nonzero fields");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.bad_index |->
         rsp_ch.tex_u <= 17'd65536 && rsp_ch.tex_v <= 17'd65536)
      else $error("texture coordinate above one");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_DIV0] && !rdy[ST_DIV0 + 1] |=>
         v_ff[ST_DIV0] && $stable(div_num_ff[0][0]))
      else $error("divider entry stage lost or changed a stalled beat");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[NS] && !rsp_ch.ready |=> v_ff[NS] && $stable(u_ff))
      else $error("output stage dropped a waiting beat");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> v_ff == '0)
      else $error("pipeline not empty after reset");

endmodule
